/* rtl/m64a_pkg.sv */
// package for the streaming murmurhash64a block
// holds the hash constants, datapath command codes and the control/status structs
// no dependencies
package m64a_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int LEN_W  = 16;
  localparam int TAIL_W = 3;

  localparam logic [WORD_W-1:0] MUL_M   = 64'hc6a4a7935bd1e995;
  localparam int                SHIFT_R = 47;

  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE    = 4'd0;
  localparam dp_op_t OP_LOAD    = 4'd1;
  localparam dp_op_t OP_MUL     = 4'd2;
  localparam dp_op_t OP_H_INIT  = 4'd3;
  localparam dp_op_t OP_K_MIX   = 4'd4;
  localparam dp_op_t OP_H_XK    = 4'd5;
  localparam dp_op_t OP_H_LOAD  = 4'd6;
  localparam dp_op_t OP_TAIL    = 4'd7;
  localparam dp_op_t OP_FIN_PRE = 4'd8;
  localparam dp_op_t OP_FIN_OUT = 4'd9;

  typedef logic [1:0] mul_src_t;
  localparam mul_src_t SRC_K   = 2'd0;
  localparam mul_src_t SRC_H   = 2'd1;
  localparam mul_src_t SRC_LEN = 2'd2;

  typedef logic [1:0] mul_step_t;
  localparam mul_step_t STEP_LL = 2'd0;
  localparam mul_step_t STEP_HL = 2'd1;
  localparam mul_step_t STEP_LH = 2'd2;

  typedef struct packed {
    dp_op_t    op;
    mul_src_t  src;
    mul_step_t step;
    logic      first;
  } dp_cmd_t;

  typedef struct packed {
    logic tail_nz;
    logic len_zero;
  } dp_sts_t;

  function automatic logic [WORD_W-1:0] shr_xor(input logic [WORD_W-1:0] x);
    shr_xor = x ^ (x >> SHIFT_R);
  endfunction

endpackage

/* rtl/m64a_dp.sv */
// datapath: key word, running hash, product accumulator, seed and result registers
// one shared 32x32 multiplier builds each 64-bit product by m in three steps
// depends on m64a_pkg
module m64a_dp (
  input  logic                   clk,
  input  m64a_pkg::dp_cmd_t      cmd,
  output m64a_pkg::dp_sts_t      sts,
  input  logic [63:0]            key_word,
  input  logic [15:0]            key_length,
  input  logic                   cfg_we,
  input  logic [63:0]            cfg_wdata,
  input  logic                   rst_n,
  output logic [63:0]            hash
);
  import m64a_pkg::*;

  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] k_r;
  logic [WORD_W-1:0] h_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] out_r;
  logic [LEN_W-1:0]  len_r;
  logic [TAIL_W-1:0] tail_r;

  logic [WORD_W-1:0] opnd;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] tail_mask;

  always_comb begin
    case (cmd.src)
      SRC_K:   opnd = k_r;
      SRC_H:   opnd = h_r;
      SRC_LEN: opnd = {{(WORD_W-LEN_W){1'b0}}, len_r};
      default: opnd = k_r;
    endcase
  end

  always_comb begin
    case (cmd.step)
      STEP_LL: begin
        mul_a = opnd[HALF_W-1:0];
        mul_b = MUL_M[HALF_W-1:0];
      end
      STEP_HL: begin
        mul_a = opnd[WORD_W-1:HALF_W];
        mul_b = MUL_M[HALF_W-1:0];
      end
      STEP_LH: begin
        mul_a = opnd[HALF_W-1:0];
        mul_b = MUL_M[WORD_W-1:HALF_W];
      end
      default: begin
        mul_a = opnd[HALF_W-1:0];
        mul_b = MUL_M[HALF_W-1:0];
      end
    endcase
  end

  assign prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

  always_comb begin
    for (int i = 0; i < WORD_W/8; i++) begin
      tail_mask[i*8 +: 8] = (i < int'(tail_r)) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        k_r <= key_word;
        if (cmd.first) begin
          len_r  <= key_length[LEN_W-1:0];
          tail_r <= key_length[TAIL_W-1:0];
        end
      end
      OP_MUL: begin
        if (cmd.step == STEP_LL) begin
          acc_r <= prod;
        end else begin
          acc_r[WORD_W-1:HALF_W] <= acc_r[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
        end
      end
      OP_H_INIT:  h_r   <= seed_r ^ acc_r;
      OP_K_MIX:   k_r   <= shr_xor(acc_r);
      OP_H_XK:    h_r   <= h_r ^ acc_r;
      OP_H_LOAD:  h_r   <= acc_r;
      OP_TAIL:    h_r   <= h_r ^ (k_r & tail_mask);
      OP_FIN_PRE: h_r   <= shr_xor(h_r);
      OP_FIN_OUT: out_r <= shr_xor(acc_r);
      default: begin
      end
    endcase
  end

  assign sts.tail_nz  = (tail_r != '0);
  assign sts.len_zero = (len_r == '0);
  assign hash         = out_r;

endmodule

/* rtl/m64a_ctrl.sv */
// controller: sequences the datapath through the mixing, tail and finalization steps
// owns the handshakes, the in-key flag and the multiply step count
// depends on m64a_pkg
module m64a_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output m64a_pkg::dp_cmd_t  cmd,
  input  m64a_pkg::dp_sts_t  sts
);
  import m64a_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LEN_MUL = 4'd1;
  localparam logic [3:0] S_H_INIT  = 4'd2;
  localparam logic [3:0] S_K_MUL1  = 4'd3;
  localparam logic [3:0] S_K_MIX   = 4'd4;
  localparam logic [3:0] S_K_MUL2  = 4'd5;
  localparam logic [3:0] S_H_XK    = 4'd6;
  localparam logic [3:0] S_H_MUL   = 4'd7;
  localparam logic [3:0] S_H_WB    = 4'd8;
  localparam logic [3:0] S_TAIL    = 4'd9;
  localparam logic [3:0] S_FIN1    = 4'd10;
  localparam logic [3:0] S_FIN_MUL = 4'd11;
  localparam logic [3:0] S_FIN_WB  = 4'd12;

  logic [3:0]  state_r, state_nxt;
  mul_step_t   step_r, step_nxt;
  logic        in_key_r, in_key_nxt;
  logic        first_r, first_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        step_done;

  function automatic logic [3:0] dispatch(input logic last, input logic tail_nz,
                                          input logic empty);
    logic [3:0] s;
    if (!last) begin
      s = S_K_MUL1;
    end else if (tail_nz) begin
      s = S_TAIL;
    end else if (empty) begin
      s = S_FIN1;
    end else begin
      s = S_K_MUL1;
    end
    dispatch = s;
  endfunction

  assign step_done = (step_r == STEP_LH);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_key_nxt    = in_key_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.src       = SRC_K;
    cmd.step      = step_r;
    cmd.first     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.first = !in_key_r;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          in_key_nxt = 1'b1;
          first_nxt  = !in_key_r;
          last_nxt   = in_last;
          if (!in_key_r) begin
            state_nxt = S_LEN_MUL;
          end else begin
            state_nxt = dispatch(in_last, sts.tail_nz, 1'b0);
          end
        end
      end
      S_LEN_MUL, S_K_MUL1, S_K_MUL2, S_H_MUL, S_FIN_MUL: begin
        cmd.op = OP_MUL;
        case (state_r)
          S_LEN_MUL: cmd.src = SRC_LEN;
          S_K_MUL1:  cmd.src = SRC_K;
          S_K_MUL2:  cmd.src = SRC_K;
          default:   cmd.src = SRC_H;
        endcase
        if (step_done) begin
          step_nxt = STEP_LL;
          case (state_r)
            S_LEN_MUL: state_nxt = S_H_INIT;
            S_K_MUL1:  state_nxt = S_K_MIX;
            S_K_MUL2:  state_nxt = S_H_XK;
            S_H_MUL:   state_nxt = S_H_WB;
            default:   state_nxt = S_FIN_WB;
          endcase
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      S_H_INIT: begin
        cmd.op    = OP_H_INIT;
        state_nxt = dispatch(last_r, sts.tail_nz, first_r && sts.len_zero);
      end
      S_K_MIX: begin
        cmd.op    = OP_K_MIX;
        state_nxt = S_K_MUL2;
      end
      S_H_XK: begin
        cmd.op    = OP_H_XK;
        state_nxt = S_H_MUL;
      end
      S_H_WB: begin
        cmd.op    = OP_H_LOAD;
        state_nxt = last_r ? S_FIN1 : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = S_H_MUL;
      end
      S_FIN1: begin
        cmd.op    = OP_FIN_PRE;
        state_nxt = S_FIN_MUL;
      end
      S_FIN_WB: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN_OUT;
          out_valid_nxt = 1'b1;
          in_key_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_LL;
      in_key_r    <= 1'b0;
      first_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      in_key_r    <= in_key_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/murmur64a_stream_hash.sv */
// MurmurHash64A over a key streamed as little-endian 64-bit words, one word per
// transaction; the first transaction of a key carries its byte length, the one with
// in_last set closes the key and yields one hash on the out channel. The seed is to
// be written through cfg_we/cfg_wdata by the user only while no key is in flight;
// the block does not enforce this. Every 64-bit product by m is built in steps
// (low*low, high*low, low*high) on a single shared 32x32 multiplier, and no new
// word is taken until the last one is fully mixed: the first word of a key also
// multiplies the length by m, and the last item adds finalization, plus any wait
// on out_ready while an earlier hash is still untaken. A finished hash sits in an
// output register, so the next key is accepted while it waits to be taken.
// depends on m64a_pkg, m64a_ctrl, m64a_dp
module murmur64a_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_key_word,
  input  logic [15:0] in_key_length,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import m64a_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  m64a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  m64a_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .key_word   (in_key_word),
    .key_length (in_key_length),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rst_n      (rst_n),
    .hash       (out_hash)
  );

endmodule

/* test/murmur64a_check.sv */
// checker for the streaming murmurhash64a block: follows every transaction on the
// key, result and seed ports, predicts each finished hash and compares it in order
// depends on m64a_pkg
module murmur64a_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_key_word,
  input  logic [15:0] in_key_length,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_hash,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          hashes_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import m64a_pkg::*;

  logic [63:0] seed_q;
  logic [63:0] run_hash;
  logic        mid_key;
  logic [2:0]  tail_len;
  logic [63:0] hash_fifo[$];

  function automatic logic [63:0] scramble_word(input logic [63:0] k);
    logic [63:0] t;
    t = k * MUL_M;
    t = t ^ (t >> SHIFT_R);
    return t * MUL_M;
  endfunction

  function automatic logic [63:0] finalize(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> SHIFT_R);
    t = t * MUL_M;
    return t ^ (t >> SHIFT_R);
  endfunction

  always @(posedge clk) begin
    logic [63:0] h;
    logic [63:0] want;
    logic        first;

    if (!rst_n) begin
      seed_q = '0;
      run_hash = '0;
      mid_key = 1'b0;
      tail_len = '0;
      hash_fifo.delete();
      fail_count = 0;
      hashes_owed = 0;
    end else begin
      if (cfg_we) seed_q = cfg_wdata;

      if (in_valid && in_ready) begin
        first = !mid_key;
        if (first) begin
          run_hash = seed_q ^ (64'(in_key_length) * MUL_M);
          tail_len = in_key_length[2:0];
          mid_key = 1'b1;
        end
        h = run_hash;
        if (!in_last) begin
          run_hash = (h ^ scramble_word(in_key_word)) * MUL_M;
        end else begin
          // bytes above the tail are ignored
          if (tail_len != 0) begin
            h = (h ^ (in_key_word & ((64'd1 << {tail_len, 3'b000}) - 64'd1))) * MUL_M;
          end else if (!(first && in_key_length == 0)) begin
            h = (h ^ scramble_word(in_key_word)) * MUL_M;
          end
          hash_fifo.push_back(finalize(h));
          run_hash = '0;
          mid_key = 1'b0;
          tail_len = '0;
        end
      end

      if (out_valid && out_ready) begin
        if (hash_fifo.size() == 0) begin
          fail_count++;
          $display("%t unexpected hash: expected none, actual %h", $time, out_hash);
        end else begin
          want = hash_fifo.pop_front();
          if (want !== out_hash) begin
            fail_count++;
            $display("%t hash mismatch: expected %h, actual %h", $time, want, out_hash);
          end
        end
      end

      hashes_owed = hash_fifo.size();
    end
  end

endmodule

/* test/tb_murmur64a_stream_hash.sv */
// top of the murmurhash64a regression: clock, reset, seed writes, key and result
// traffic with random gaps (none in every third random phase), and the verdict
// depends on m64a_pkg, murmur64a_stream_hash and murmur64a_check
module tb_murmur64a_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;
  import m64a_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int KEY_ITEMS   = 1750;
  localparam int PHASE_ITEMS = 300;
  localparam int SETTLE      = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_key_word;
  logic [15:0] in_key_length;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  int fail_count;
  int hashes_owed;
  int cycles = 0;
  int items_sent = 0;
  bit no_gaps = 1'b0;

  always #5ns clk = ~clk;

  murmur64a_stream_hash uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_key_word  (in_key_word),
    .in_key_length(in_key_length),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hash     (out_hash),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  murmur64a_check checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic push_item(input logic [63:0] word, input logic [15:0] len, input bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_key_word   <= word;
    in_key_length <= len;
    in_last       <= fin;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic push_key(input logic [15:0] len, input int words);
    for (int i = 0; i < words; i++)
      push_item({$urandom, $urandom}, (i == 0) ? len : 16'($urandom), i == words - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (hashes_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] s);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_wdata <= s;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int phase;
    int quota;
    int pick;
    int nbytes;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_key_word   <= '0;
    in_key_length <= '0;
    in_last       <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed keys with the reset seed
    push_item('0, 16'd0, 1'b1);
    push_item('1, 16'd8, 1'b1);
    push_item('0, 16'd8, 1'b1);
    push_item('1, 16'd1, 1'b1);
    push_item(64'h0123456789abcdef, 16'd7, 1'b1);
    push_item('1, 16'hffff, 1'b1);
    push_item('1, 16'hfff8, 1'b1);
    push_item('1, 16'd16, 1'b0);
    push_item('1, 16'hffff, 1'b1);
    push_item(64'h8000000000000000, 16'd15, 1'b0);
    push_item('1, 16'd0, 1'b1);
    // zero length but more than one word
    push_item('1, 16'd0, 1'b0);
    push_item('1, 16'hffff, 1'b1);

    load_seed('1);
    push_item('0, 16'd0, 1'b1);
    push_item('1, 16'd9, 1'b0);
    push_item(64'h00000000000000ff, 16'd9, 1'b1);
    push_item('1, 16'd3, 1'b1);

    load_seed(64'd1);
    push_item('0, 16'd8, 1'b1);
    push_key(16'd24, 3);

    phase = 0;
    while (items_sent < KEY_ITEMS) begin
      case (phase % 5)
        0: load_seed('0);
        1: load_seed('1);
        2: load_seed(64'h8000000000000000);
        default: load_seed({$urandom, $urandom});
      endcase
      no_gaps = (phase % 3 == 2);
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota && items_sent < KEY_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          nbytes = $urandom_range(0, 48);
          push_key(16'(nbytes), (nbytes == 0) ? 1 : (nbytes + 7) / 8);
        end else if (pick < 88) begin
          nbytes = $urandom_range(49, 160);
          push_key(16'(nbytes), (nbytes + 7) / 8);
        end else if (pick < 95) begin
          push_key(16'($urandom), $urandom_range(1, 4));
        end else if (pick < 98) begin
          push_key(16'($urandom_range(0, 40)), $urandom_range(1, 6));
        end else begin
          drain();
        end
      end
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* filelist.f */
rtl/m64a_pkg.sv
rtl/m64a_dp.sv
rtl/m64a_ctrl.sv
rtl/murmur64a_stream_hash.sv
test/murmur64a_check.sv
test/tb_murmur64a_stream_hash.sv
